@@ hw/rtl/ascon_pkg.sv @@
// Shared types, constants and the round function of the Ascon permutation core.
// Used by ascon_ctrl, ascon_dp and ascon_permutation; depends on nothing else.
package ascon_pkg;

    localparam int WORD_W  = 64;
    localparam int NUM_WORDS = 5;
    localparam int RC_W    = 8;
    localparam int STATE_W = WORD_W * NUM_WORDS;
    localparam int IN_W    = STATE_W + RC_W;

    // Rounds run while the round constant is above the floor.
    localparam logic [RC_W-1:0] RC_FLOOR = 8'h3c;
    localparam logic [RC_W-1:0] RC_STEP  = 8'd15;

    typedef logic [WORD_W-1:0] word_t;
    typedef word_t [NUM_WORDS-1:0] state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;
        logic round;
        logic capture;
    } ascon_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic more_rounds;
    } ascon_status_t;

    // Rotate a 64-bit word right by a fixed amount.
    function automatic word_t rotr64(input word_t x, input int unsigned n);
        word_t r;
        r = (x >> n) | (x << (WORD_W - n));
        return r;
    endfunction

    // One full round: constant addition, bitsliced S-box, linear layer.
    function automatic state_t ascon_round(input state_t w, input logic [RC_W-1:0] rc);
        word_t a0, a1, a2, a3, a4;
        word_t b0, b1, b2, b3, b4;
        state_t r;
        a0 = w[0];
        a1 = w[1];
        a2 = w[2] ^ {{(WORD_W-RC_W){1'b0}}, rc};
        a3 = w[3];
        a4 = w[4];

        // Substitution layer in its bitsliced form.
        a0 = a0 ^ a4;
        a4 = a4 ^ a3;
        a2 = a2 ^ a1;
        b0 = ~a0 & a1;
        b1 = ~a1 & a2;
        b2 = ~a2 & a3;
        b3 = ~a3 & a4;
        b4 = ~a4 & a0;
        a0 = a0 ^ b1;
        a1 = a1 ^ b2;
        a2 = a2 ^ b3;
        a3 = a3 ^ b4;
        a4 = a4 ^ b0;
        a1 = a1 ^ a0;
        a0 = a0 ^ a4;
        a3 = a3 ^ a2;
        a2 = ~a2;

        // Linear diffusion layer.
        r[0] = a0 ^ rotr64(a0, 19) ^ rotr64(a0, 28);
        r[1] = a1 ^ rotr64(a1, 61) ^ rotr64(a1, 39);
        r[2] = a2 ^ rotr64(a2, 1)  ^ rotr64(a2, 6);
        r[3] = a3 ^ rotr64(a3, 10) ^ rotr64(a3, 17);
        r[4] = a4 ^ rotr64(a4, 7)  ^ rotr64(a4, 41);
        return r;
    endfunction

endpackage

@@ hw/rtl/ascon_ctrl.sv @@
// Controller of the Ascon permutation core: sequences load, rounds and
// hand-off to the output register. Depends on ascon_pkg.
module ascon_ctrl
    import ascon_pkg::*;
(
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_tvalid,
    output logic          s_tready,
    output logic          m_tvalid,
    input  logic          m_tready,
    input  ascon_status_t status,
    output ascon_cmd_t    cmd
);

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_RUN  = 2'b10
    } ctrl_state_t;

    ctrl_state_t state_reg, state_next;
    logic        out_valid_reg, out_valid_next;
    logic        out_free;

    // The output register can take a result when empty or being drained.
    assign out_free = !out_valid_reg || m_tready;

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = out_valid_reg;

    // Next state and datapath commands.
    always_comb begin
        state_next  = state_reg;
        cmd.load    = 1'b0;
        cmd.round   = 1'b0;
        cmd.capture = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    cmd.load   = 1'b1;
                    state_next = ST_RUN;
                end
            end
            ST_RUN: begin
                if (status.more_rounds) begin
                    cmd.round = 1'b1;
                end else if (out_free) begin
                    cmd.capture = 1'b1;
                    state_next  = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Output valid flag: set on capture, cleared when the result is taken.
    always_comb begin
        out_valid_next = out_valid_reg;
        if (cmd.capture) begin
            out_valid_next = 1'b1;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

@@ hw/rtl/ascon_dp.sv @@
// Datapath of the Ascon permutation core: working state, round constant,
// one round unit and the output register. Depends on ascon_pkg.
module ascon_dp
    import ascon_pkg::*;
(
    input  logic               aclk,
    input  ascon_cmd_t         cmd,
    input  logic [IN_W-1:0]    in_data,
    output ascon_status_t      status,
    output logic [STATE_W-1:0] out_data
);

    state_t            state_reg, state_next;
    logic [RC_W-1:0]   rc_reg, rc_next;
    state_t            out_reg, out_next;

    // Another round is due while the constant stays above the floor.
    assign status.more_rounds = (rc_reg > RC_FLOOR);

    // Working state, round constant and output register update.
    always_comb begin
        state_next = state_reg;
        rc_next    = rc_reg;
        out_next   = out_reg;
        if (cmd.load) begin
            state_next = state_t'(in_data[STATE_W-1:0]);
            rc_next    = in_data[IN_W-1:STATE_W];
        end else if (cmd.round) begin
            state_next = ascon_round(state_reg, rc_reg);
            rc_next    = rc_reg - RC_STEP;
        end
        if (cmd.capture) begin
            out_next = state_reg;
        end
    end

    always_ff @(posedge aclk) begin
        state_reg <= state_next;
        rc_reg    <= rc_next;
        out_reg   <= out_next;
    end

    assign out_data = out_reg;

endmodule

@@ hw/rtl/ascon_permutation.sv @@
// Top level of the Ascon 320-bit permutation core with stream interfaces.
// Instantiates ascon_ctrl and ascon_dp; depends on ascon_pkg.
//
//  Channel  | Direction | Handshake          | Payload
//  ---------+-----------+--------------------+-------------------------------------
//  s_       | in        | s_tvalid/s_tready  | 5 state words, start round constant
//  m_       | out       | m_tvalid/m_tready  | 5 permuted state words
//
// An item is loaded on acceptance, then runs n rounds, where n is set by the start
// round constant (0 to 13; 12 for a start constant of 0xf0), and is then captured in
// the output register. The next request is taken once the core is back in idle.
// The single round unit in the datapath runs one round per cycle.
// Reset is synchronous and active low; it clears the controller and output valid.
// A new request is accepted while a finished result waits in the output register;
// a stalled output holds the core in its last step until the register frees up.
module ascon_permutation
    import ascon_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_tvalid,
    output logic               s_tready,
    // word0_in [63:0], word1_in, word2_in, word3_in, word4_in [319:256],
    // start_constant [327:320]
    input  logic [IN_W-1:0]    s_tdata,
    output logic               m_tvalid,
    input  logic               m_tready,
    // word0_out [63:0], word1_out, word2_out, word3_out, word4_out [319:256]
    output logic [STATE_W-1:0] m_tdata
);

    ascon_cmd_t    cmd;
    ascon_status_t status;

    // Sequencing of load, rounds and output hand-off.
    ascon_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .status   (status),
        .cmd      (cmd)
    );

    // State registers and the round unit.
    ascon_dp u_dp (
        .aclk     (aclk),
        .cmd      (cmd),
        .in_data  (s_tdata),
        .status   (status),
        .out_data (m_tdata)
    );

endmodule
